// ----- hdl/pwsr_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and constants of the pulse width sensor responder
package pwsr_pkg;

	// reply phases, also the phase code of a result
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_INIT = 3'd1,
		PH_LEAD = 3'd2,
		PH_TEMP = 3'd3,
		PH_GAP  = 3'd4,
		PH_HUM  = 3'd5
	} phase_t;

	// request kinds
	localparam logic REQ_EDGE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HUMIDITY    = 1'd1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_DATA_W-1:0] TEMP_RESET = 8'd23;
	localparam logic [CFG_DATA_W-1:0] HUM_RESET  = 8'd90;

	// thresholds in ns, largest is (15 + 255*10) * 1000 = 2565000
	localparam int THR_W = 22;
	typedef logic [THR_W-1:0] thr_ns_t;

	localparam thr_ns_t MIN_REQ_NS  = 22'd1000;
	localparam thr_ns_t GAP_NS      = 22'd10000;
	localparam thr_ns_t STEP_NS     = 22'd10000;
	localparam thr_ns_t TEMP_BASE_NS = 22'd10000;
	localparam thr_ns_t HUM_BASE_NS  = 22'd15000;

	typedef struct packed {
		thr_ns_t temp;
		thr_ns_t hum;
	} pulse_thr_t;

	// (10 + t*10) * 1000
	function automatic thr_ns_t temp_threshold(input logic [CFG_DATA_W-1:0] t);
		return THR_W'(t) * STEP_NS + TEMP_BASE_NS;
	endfunction

	// (15 + h*10) * 1000
	function automatic thr_ns_t hum_threshold(input logic [CFG_DATA_W-1:0] h);
		return THR_W'(h) * STEP_NS + HUM_BASE_NS;
	endfunction

endpackage

// ----- hdl/pwsr_if.sv -----
`timescale 1ns / 1ps
// request and response channel interfaces of the pulse width sensor responder
interface pwsr_in_if #(
	parameter int TIME_BITS = 48
);
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic [TIME_BITS-1:0] now_ns;

	modport source (output valid, output req_type, output now_ns, input ready);
	modport sink   (input valid, input req_type, input now_ns, output ready);
endinterface

interface pwsr_out_if;
	logic       valid;
	logic       ready;
	logic       line_level;
	logic       init_rejected;
	logic [2:0] phase;

	modport source (output valid, output line_level, output init_rejected, output phase,
		input ready);
	modport sink   (input valid, input line_level, input init_rejected, input phase,
		output ready);
endinterface

// ----- hdl/pwsr_cfg.sv -----
`timescale 1ns / 1ps
// configuration registers, kept as pulse width thresholds in ns
module pwsr_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [pwsr_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [pwsr_pkg::CFG_DATA_W-1:0]  wr_data,
	output pwsr_pkg::pulse_thr_t             thr
);

	pwsr_pkg::pulse_thr_t thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.temp <= pwsr_pkg::temp_threshold(pwsr_pkg::TEMP_RESET);
			thr_q.hum  <= pwsr_pkg::hum_threshold(pwsr_pkg::HUM_RESET);
		end else if (wr_en) begin
			case (wr_index)
				pwsr_pkg::CFG_TEMPERATURE: thr_q.temp <= pwsr_pkg::temp_threshold(wr_data);
				pwsr_pkg::CFG_HUMIDITY:    thr_q.hum  <= pwsr_pkg::hum_threshold(wr_data);
				default: ;
			endcase
		end
	end

	assign thr = thr_q;

endmodule

// ----- hdl/pwsr_engine.sv -----
`timescale 1ns / 1ps
// input register, phase state machine and result register
module pwsr_engine #(
	parameter int TIME_BITS = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pwsr_pkg::pulse_thr_t  thr,
	pwsr_in_if.sink               req,
	pwsr_out_if.source            rsp
);

	// input stage
	logic                 valid_s1;
	logic                 req_type_s1;
	logic [TIME_BITS-1:0] now_s1;

	// state
	pwsr_pkg::phase_t     phase_q, phase_n;
	logic [TIME_BITS-1:0] start_q, start_n;
	logic                 level_q, level_n;
	logic                 rej_n;

	// result register
	logic       res_valid_q;
	logic       line_level_q;
	logic       rej_q;
	logic [2:0] phase_res_q;

	logic                 advance;
	logic [TIME_BITS-1:0] dt;
	logic [TIME_BITS-1:0] limit;
	logic                 over;

	assign advance   = valid_s1 && (!res_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			now_s1      <= req.now_ns;
		end
	end

	// one start time serves both the request window and the reply phases
	assign dt = now_s1 - start_q;

	always_comb begin
		case (phase_q)
			pwsr_pkg::PH_INIT: limit = TIME_BITS'(pwsr_pkg::MIN_REQ_NS);
			pwsr_pkg::PH_TEMP: limit = TIME_BITS'(thr.temp);
			pwsr_pkg::PH_HUM:  limit = TIME_BITS'(thr.hum);
			default:           limit = TIME_BITS'(pwsr_pkg::GAP_NS);
		endcase
	end

	assign over = dt > limit;

	always_comb begin
		phase_n = phase_q;
		start_n = start_q;
		level_n = level_q;
		rej_n   = 1'b0;
		if (req_type_s1 == pwsr_pkg::REQ_EDGE) begin
			case (phase_q)
				pwsr_pkg::PH_IDLE: begin
					phase_n = pwsr_pkg::PH_INIT;
					start_n = now_s1;
				end
				pwsr_pkg::PH_INIT: begin
					if (over) begin
						phase_n = pwsr_pkg::PH_LEAD;
						start_n = now_s1;
					end else begin
						rej_n = 1'b1;
					end
				end
				default: ;
			endcase
		end else begin
			case (phase_q)
				pwsr_pkg::PH_LEAD: begin
					if (over) begin
						phase_n = pwsr_pkg::PH_TEMP;
						level_n = 1'b1;
						start_n = now_s1;
					end
				end
				pwsr_pkg::PH_TEMP: begin
					if (over) begin
						phase_n = pwsr_pkg::PH_GAP;
						level_n = 1'b0;
						start_n = now_s1;
					end
				end
				pwsr_pkg::PH_GAP: begin
					if (over) begin
						phase_n = pwsr_pkg::PH_HUM;
						level_n = 1'b1;
						start_n = now_s1;
					end
				end
				pwsr_pkg::PH_HUM: begin
					if (over) begin
						phase_n = pwsr_pkg::PH_IDLE;
						level_n = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pwsr_pkg::PH_IDLE;
			start_q <= '0;
			level_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			start_q <= start_n;
			level_q <= level_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			line_level_q <= level_n;
			rej_q        <= rej_n;
			phase_res_q  <= phase_n;
		end
	end

	assign rsp.valid         = res_valid_q;
	assign rsp.line_level    = line_level_q;
	assign rsp.init_rejected = rej_q;
	assign rsp.phase         = phase_res_q;

	// a rejected edge always leaves the block in init, waiting for the edge that closes the request
	a_rej_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && rej_q |-> phase_res_q == pwsr_pkg::PH_INIT)
		else $error("rejection reported outside init phase");

	// the line is driven high only during the two data pulses
	a_level_phase: assert property (@(posedge clk) disable iff (!arst_n)
		level_q |-> (phase_q == pwsr_pkg::PH_TEMP || phase_q == pwsr_pkg::PH_HUM))
		else $error("reply line high outside a data pulse");

	// state only moves when an item passes into the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(start_q) && $stable(level_q))
		else $error("state changed without a transaction");

	// every item that leaves the input stage shows up as a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("processed item produced no result");

endmodule

// ----- hdl/pulse_width_sensor_responder_core.sv -----
`timescale 1ns / 1ps
// top level of the pulse width sensor responder
// a request passes two registers, the input register and the result register, before its response transaction
// throughput: one request transaction per cycle, sustained, as long as responses are taken
// the phase state updates once per request, so each request sees the state its predecessor left
// reset: arst_n sets idle, line low, start time zero, temperature 23 and humidity 90
module pulse_width_sensor_responder_core #(
	parameter int TIME_BITS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port, register 0 temperature, register 1 humidity
	input  logic                            wr_en,
	input  logic [pwsr_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [pwsr_pkg::CFG_DATA_W-1:0] wr_data,
	// request channel: edge or tick with its timestamp
	pwsr_in_if.sink                         req,
	// response channel: line level, rejection flag and phase after each request
	pwsr_out_if.source                      rsp
);

	// pulse thresholds, kept in ns so the datapath only subtracts and compares
	pwsr_pkg::pulse_thr_t thr;

	// configuration registers, converted to thresholds when written
	pwsr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.thr      (thr)
	);

	// input register, one wraparound subtract and compare per request, result register
	pwsr_engine #(
		.TIME_BITS (TIME_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.thr    (thr),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ----- dv/pulse_width_sensor_responder_core_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the pulse width sensor responder core
module pulse_width_sensor_responder_core_test;

	localparam int TIME_BITS = 48;
	typedef logic [TIME_BITS-1:0] stamp_t;

	// timing rules of the reply, in ns
	localparam stamp_t MIN_HOLD_NS    = 1000;
	localparam stamp_t REPLY_GAP_NS   = 10000;
	localparam stamp_t PULSE_STEP_NS  = 10000;
	localparam stamp_t TEMP_OFFSET_NS = 10000;
	localparam stamp_t HUM_OFFSET_NS  = 15000;
	localparam logic [7:0] DEFAULT_TEMP = 8'd23;
	localparam logic [7:0] DEFAULT_HUM  = 8'd90;

	// run control
	localparam int RANDOM_ITEMS   = 1820;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	// one response transaction as the checker sees it
	typedef struct packed {
		logic             level;
		logic             rejected;
		pwsr_pkg::phase_t phase;
	} reply_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [pwsr_pkg::CFG_IDX_W-1:0] wr_index;
	logic [pwsr_pkg::CFG_DATA_W-1:0] wr_data;

	pwsr_in_if #(.TIME_BITS(TIME_BITS)) req_ch ();
	pwsr_out_if rsp_ch ();

	pulse_width_sensor_responder_core #(
		.TIME_BITS(TIME_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// responder state mirrored by the testbench
	pwsr_pkg::phase_t reply_phase = pwsr_pkg::PH_IDLE;
	stamp_t request_t0  = '0;
	stamp_t phase_t0    = '0;
	logic   line_lvl    = 1'b0;
	logic [7:0] temp_reg = DEFAULT_TEMP;
	logic [7:0] hum_reg  = DEFAULT_HUM;

	reply_t expected_replies[$];
	int unsigned mismatches   = 0;
	int unsigned items_sent   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned stall_left   = 0;
	bit src_idle_on  = 1'b1;
	bit snk_stall_on = 1'b1;

	// time stamp the stimulus has reached so far
	stamp_t stim_t = '0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// length of one idle stretch: mostly short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// time a phase must exceed before the reply moves on
	function automatic stamp_t phase_limit(pwsr_pkg::phase_t ph);
		case (ph)
			pwsr_pkg::PH_TEMP: return stamp_t'(temp_reg) * PULSE_STEP_NS + TEMP_OFFSET_NS;
			pwsr_pkg::PH_HUM:  return stamp_t'(hum_reg) * PULSE_STEP_NS + HUM_OFFSET_NS;
			default:           return REPLY_GAP_NS;
		endcase
	endfunction

	// advance the mirrored responder by one request and give the reply it makes
	function automatic reply_t sensor_step(logic kind, stamp_t t);
		reply_t r;
		stamp_t dt;
		r.rejected = 1'b0;
		// elapsed times wrap modulo the stamp width
		dt = t - phase_t0;
		if (kind == pwsr_pkg::REQ_EDGE) begin
			if (reply_phase == pwsr_pkg::PH_IDLE) begin
				request_t0  = t;
				reply_phase = pwsr_pkg::PH_INIT;
			end else if (reply_phase == pwsr_pkg::PH_INIT) begin
				// an early edge keeps the first edge as reference
				if (stamp_t'(t - request_t0) > MIN_HOLD_NS) begin
					reply_phase = pwsr_pkg::PH_LEAD;
					phase_t0    = t;
				end else begin
					r.rejected = 1'b1;
				end
			end
			// edges during the reply change nothing
		end else begin
			case (reply_phase)
				pwsr_pkg::PH_LEAD: if (dt > phase_limit(pwsr_pkg::PH_LEAD)) begin
					reply_phase = pwsr_pkg::PH_TEMP;
					line_lvl    = 1'b1;
					phase_t0    = t;
				end
				pwsr_pkg::PH_TEMP: if (dt > phase_limit(pwsr_pkg::PH_TEMP)) begin
					reply_phase = pwsr_pkg::PH_GAP;
					line_lvl    = 1'b0;
					phase_t0    = t;
				end
				pwsr_pkg::PH_GAP: if (dt > phase_limit(pwsr_pkg::PH_GAP)) begin
					reply_phase = pwsr_pkg::PH_HUM;
					line_lvl    = 1'b1;
					phase_t0    = t;
				end
				pwsr_pkg::PH_HUM: if (dt > phase_limit(pwsr_pkg::PH_HUM)) begin
					// back to idle, the phase start time is left as it was
					reply_phase = pwsr_pkg::PH_IDLE;
					line_lvl    = 1'b0;
				end
				default: ;
			endcase
			// ticks in idle or init are ignored
		end
		r.level = line_lvl;
		r.phase = reply_phase;
		return r;
	endfunction

	// one request transaction; valid stays high when the next one follows at once
	task automatic send_item(input logic kind, input stamp_t t);
		int unsigned gap;
		gap = (src_idle_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.now_ns   <= t;
		do @(posedge clk); while (!req_ch.ready);
		expected_replies.push_back(sensor_step(kind, t));
		items_sent++;
	endtask

	// register write, only once every pending reply has come back
	task automatic write_reg(input logic [pwsr_pkg::CFG_IDX_W-1:0] idx,
		input logic [pwsr_pkg::CFG_DATA_W-1:0] val);
		req_ch.valid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == pwsr_pkg::CFG_TEMPERATURE)
			temp_reg = val;
		else
			hum_reg = val;
	endtask

	// a whole reply with every threshold hit exactly and just past it
	task automatic walk_reply_limits(input stamp_t t0);
		stamp_t p;
		stamp_t thr;
		send_item(pwsr_pkg::REQ_EDGE, t0);
		// tick while waiting for the edge that closes the request
		send_item(pwsr_pkg::REQ_TICK, t0 + 5);
		// closing edge of the request exactly at the limit is too soon
		send_item(pwsr_pkg::REQ_EDGE, t0 + MIN_HOLD_NS);
		p = t0 + MIN_HOLD_NS + 1;
		send_item(pwsr_pkg::REQ_EDGE, p);
		// edge inside the reply is ignored
		send_item(pwsr_pkg::REQ_EDGE, p + 7);
		// lead gap, temperature pulse, gap, humidity pulse
		repeat (4) begin
			thr = phase_limit(reply_phase);
			send_item(pwsr_pkg::REQ_TICK, p + thr);
			p = p + thr + 1;
			send_item(pwsr_pkg::REQ_TICK, p);
		end
		// tick back in idle
		stim_t = p + 3;
		send_item(pwsr_pkg::REQ_TICK, stim_t);
	endtask

	// reset values of the registers, times starting at zero
	task automatic test_default_thresholds();
		walk_reply_limits('0);
	endtask

	// widest temperature, narrowest humidity, reply straddling the stamp wrap
	task automatic test_extreme_registers_with_wrap();
		write_reg(pwsr_pkg::CFG_TEMPERATURE, 8'd255);
		write_reg(pwsr_pkg::CFG_HUMIDITY, 8'd0);
		walk_reply_limits('1);
	endtask

	// random replies steered from the mirrored state, with some noise mixed in
	task automatic test_random_requests();
		stamp_t thr;
		stamp_t dt_now;
		stamp_t target;
		stamp_t d;
		logic [pwsr_pkg::CFG_DATA_W-1:0] val;
		int unsigned pick;
		int unsigned start_count;
		start_count = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			// switch idling on and off in stretches
			if ((items_sent % 200) == 0) begin
				src_idle_on  = ($urandom_range(0, 3) != 0);
				snk_stall_on = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 99) < 10) begin
				// noise: any kind, any stamp
				if ($urandom_range(0, 1))
					stim_t = stamp_t'({$urandom(), $urandom()});
				else
					stim_t = stim_t + $urandom_range(0, 20000);
				send_item(1'($urandom_range(0, 1)), stim_t);
			end else begin
				case (reply_phase)
					pwsr_pkg::PH_IDLE: begin
						// new register setting between requests now and then
						if ($urandom_range(0, 3) == 0) begin
							for (int k = 0; k < 2; k++) begin
								case ($urandom_range(0, 5))
									0:       val = 8'd0;
									1:       val = 8'd255;
									2, 3:    val = 8'($urandom_range(0, 15));
									default: val = 8'($urandom_range(0, 255));
								endcase
								if (k == 0 && $urandom_range(0, 1))
									write_reg(pwsr_pkg::CFG_TEMPERATURE, val);
								else if (k == 1 && $urandom_range(0, 1))
									write_reg(pwsr_pkg::CFG_HUMIDITY, val);
							end
						end
						if ($urandom_range(0, 9) == 0)
							stim_t = stamp_t'({$urandom(), $urandom()});
						else
							stim_t = stim_t + $urandom_range(0, 50000);
						send_item(pwsr_pkg::REQ_EDGE, stim_t);
					end
					pwsr_pkg::PH_INIT: begin
						if ($urandom_range(0, 9) == 0) begin
							stim_t = stim_t + $urandom_range(0, 500);
							send_item(pwsr_pkg::REQ_TICK, stim_t);
						end else begin
							// closing edge of the request, often right on the limit
							case ($urandom_range(0, 9))
								0, 1:    d = MIN_HOLD_NS;
								2:       d = MIN_HOLD_NS + 1;
								3:       d = stamp_t'($urandom_range(0, 999));
								default: d = stamp_t'($urandom_range(1001, 4000));
							endcase
							if (d <= stamp_t'(stim_t - request_t0))
								stim_t = stim_t + $urandom_range(1, 500);
							else
								stim_t = request_t0 + d;
							send_item(pwsr_pkg::REQ_EDGE, stim_t);
						end
					end
					default: begin
						if ($urandom_range(0, 9) == 0) begin
							stim_t = stim_t + $urandom_range(0, 3000);
							send_item(pwsr_pkg::REQ_EDGE, stim_t);
						end else begin
							// tick aimed at, past or short of the phase limit
							thr    = phase_limit(reply_phase);
							dt_now = stim_t - phase_t0;
							pick   = $urandom_range(0, 9);
							case (pick)
								0:       target = thr;
								1:       target = thr + 1;
								8, 9:    target = dt_now + $urandom_range(1, 2 * int'(thr));
								default: target = dt_now + $urandom_range(1, int'(thr / 4) + 1);
							endcase
							if (target <= dt_now)
								target = dt_now + 1;
							stim_t = phase_t0 + target;
							send_item(pwsr_pkg::REQ_TICK, stim_t);
						end
					end
				endcase
			end
		end
	endtask

	// response side: random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (snk_stall_on && $urandom_range(0, 99) < 25) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= idle_len() - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// compare each response transaction with the oldest expected reply
	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_replies.size() == 0) begin
				$error("response transaction with no request waiting for it");
				mismatches++;
			end else begin
				want = expected_replies.pop_front();
				if (rsp_ch.line_level !== want.level) begin
					$error("line_level: expected %0d, got %0d", want.level, rsp_ch.line_level);
					mismatches++;
				end
				if (rsp_ch.init_rejected !== want.rejected) begin
					$error("init_rejected: expected %0d, got %0d", want.rejected,
						rsp_ch.init_rejected);
					mismatches++;
				end
				if (rsp_ch.phase !== want.phase) begin
					$error("phase: expected %0d, got %0d", want.phase, rsp_ch.phase);
					mismatches++;
				end
			end
		end
	end

	// stop a hung run: too long without any transaction
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("pulse_width_sensor_responder_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n          <= 1'b0;
		wr_en           <= 1'b0;
		wr_index        <= pwsr_pkg::CFG_TEMPERATURE;
		wr_data         <= '0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= pwsr_pkg::REQ_EDGE;
		req_ch.now_ns   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_thresholds();
		test_extreme_registers_with_wrap();
		test_random_requests();

		// let the last replies come back
		req_ch.valid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_replies.size() == 0)
			$display("pulse_width_sensor_responder_core regression: pass");
		else
			$display("pulse_width_sensor_responder_core regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/pwsr_pkg.sv
hdl/pwsr_if.sv
hdl/pwsr_cfg.sv
hdl/pwsr_engine.sv
hdl/pulse_width_sensor_responder_core.sv
dv/pulse_width_sensor_responder_core_test.sv
